[design/drunken_bishop_randomart_unit_assert.svh]
// ----------------------------------------------------------------------------
// drunken bishop randomart assertion macros
// implication checks sampled on clk, muted while rst is high
// ----------------------------------------------------------------------------
`ifndef DRUNKEN_BISHOP_RANDOMART_UNIT_ASSERT_SVH
`define DRUNKEN_BISHOP_RANDOMART_UNIT_ASSERT_SVH

// same-cycle implication
`define DBR_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBR_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[design/dbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbr_pkg
// shared constants and types of the drunken bishop randomart unit
// ----------------------------------------------------------------------------
package dbr_pkg;

  localparam int MAX_WIDTH    = 32;
  localparam int MAX_HEIGHT   = 32;
  localparam int COUNT_BITS   = 8;
  localparam int SYMBOL_COUNT = 15;

  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS  = X_BITS + Y_BITS;
  localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int CFG_BITS   = 6;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_WALK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_PEEK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_START_X     = 3'd2,
    REG_START_Y     = 3'd3,
    REG_HIGH_FIRST  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_LOOKUP,
    ST_DONE
  } state_t;

endpackage

[design/dbr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/drunken_bishop_randomart_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drunken_bishop_randomart_unit
// randomart walker: visit grid in ram, bishop moves driven by hash bytes
// ----------------------------------------------------------------------------
// usage
//   requests arrive on in_valid / in_stall with req_type, data_byte, cell_x,
//   cell_y; every request gives exactly one result transfer on out_valid /
//   out_stall carrying visit_count, symbol_index, pos_x, pos_y.
//   start: sweeps the 1024-cell grid to zero and places the bishop before the result.
//   walk: four moves, one grid read issued per cycle, each read-modify-write
//     finishing in the cycle after its read; the pace of a walk byte is set by
//     the single ram read port and the move chain.
//   read and peek request: one ram read, then the result.
//   one request is worked on at a time; in_stall is high while busy.
//   a finished result sits in the output register while the next request is
//   taken; a stalled receiver only holds the block once it has a new result.
//   reset: config returns to 17 x 9, centered start, lsb-first; the grid is
//     swept to zero with in_stall high, no result given.
//   config writes (cfg_wr_en, cfg_index, cfg_data) take effect at once; the user
//     must make them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module drunken_bishop_randomart_unit
  import dbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            req_type,
  input  logic [7:0]            data_byte,
  input  logic [4:0]            cell_x,
  input  logic [4:0]            cell_y,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            visit_count,
  output logic [3:0]            symbol_index,
  output logic [4:0]            pos_x,
  output logic [4:0]            pos_y
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] SYM_LAST  = COUNT_BITS'(SYMBOL_COUNT - 1);

  // config registers
  logic [CFG_BITS-1:0] grid_width;
  logic [CFG_BITS-1:0] grid_height;
  logic [CFG_BITS-1:0] start_x;
  logic [CFG_BITS-1:0] start_y;
  logic                high_first;

  // control and datapath registers
  state_t                state, state_next;
  logic [ADDR_BITS-1:0]  clr_addr;
  logic                  clr_report;
  logic [1:0]            move_idx;
  logic [7:0]            walk_byte;
  logic [X_BITS-1:0]     bishop_x;
  logic [Y_BITS-1:0]     bishop_y;
  logic                  in_grid;
  logic [COUNT_BITS-1:0] res_count;

  // read-modify-write second stage
  logic                  s2_valid;
  logic [ADDR_BITS-1:0]  s2_addr;
  logic                  s2_fwd;
  logic [COUNT_BITS-1:0] s2_fwd_val;

  // ram port
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  logic                  in_xfer;
  logic                  out_free;
  logic                  clr_last;
  req_t                  req;
  logic [CFG_BITS-1:0]   w_eff, h_eff;
  logic [1:0]            move_code;
  logic [X_BITS-1:0]     step_x;
  logic [Y_BITS-1:0]     step_y;
  logic [ADDR_BITS-1:0]  step_addr;
  logic [COUNT_BITS-1:0] old_count, new_count;

  // one axis of a move: clamp into the grid first, then step and clamp again
  function automatic logic [CFG_BITS-1:0] step_axis(input logic [CFG_BITS-1:0] p,
                                                    input logic plus,
                                                    input logic [CFG_BITS-1:0] size);
    logic [CFG_BITS-1:0] q;
    q = p;
    if (q >= size) q = size - CFG_BITS'(1);
    if (plus) begin
      if (q + CFG_BITS'(1) >= size) q = size - CFG_BITS'(1);
      else q = q + CFG_BITS'(1);
    end else if (q != '0) begin
      q = q - CFG_BITS'(1);
    end
    return q;
  endfunction

  // start coordinate: all ones centers, other negatives pin to zero, too large clamps to the edge
  function automatic logic [CFG_BITS-1:0] start_coord(input logic [CFG_BITS-1:0] r,
                                                      input logic [CFG_BITS-1:0] size);
    logic [CFG_BITS-1:0] q;
    if (r == '1) q = size >> 1;
    else if (r[CFG_BITS-1]) q = '0;
    else if (r >= size) q = size - CFG_BITS'(1);
    else q = r;
    return q;
  endfunction

  function automatic logic [CFG_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] v,
                                                   input logic [CFG_BITS-1:0] maxv);
    logic [CFG_BITS-1:0] q;
    if (v == '0) q = CFG_BITS'(1);
    else if (v > maxv) q = maxv;
    else q = v;
    return q;
  endfunction

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clr_last = (clr_addr == ADDR_BITS'(GRID_CELLS - 1));
  assign req      = req_t'(req_type);

  assign w_eff = eff_size(grid_width, CFG_BITS'(MAX_WIDTH));
  assign h_eff = eff_size(grid_height, CFG_BITS'(MAX_HEIGHT));

  // move code of the pair in turn; the byte register shifts one pair a step
  assign move_code = high_first ? walk_byte[7:6] : walk_byte[1:0];
  assign step_x    = X_BITS'(step_axis(CFG_BITS'(bishop_x), move_code[0], w_eff));
  assign step_y    = Y_BITS'(step_axis(CFG_BITS'(bishop_y), move_code[1], h_eff));
  assign step_addr = {step_y, step_x};

  // second stage: previous move's write forwarded when it hit the same cell
  assign old_count = s2_fwd ? s2_fwd_val : mem_rdata;
  assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_BITS'(1);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_BITS'(17);
      grid_height <= CFG_BITS'(9);
      start_x     <= '1;
      start_y     <= '1;
      high_first  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_START_X:     start_x     <= cfg_data;
        REG_START_Y:     start_y     <= cfg_data;
        REG_HIGH_FIRST:  high_first  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = clr_report ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (req)
            REQ_START: state_next = ST_CLEAR;
            REQ_WALK:  state_next = ST_WALK;
            REQ_READ:  state_next = ST_LOOKUP;
            REQ_PEEK:  state_next = ST_LOOKUP;
            default:   state_next = ST_LOOKUP;
          endcase
        end
      end
      ST_WALK: begin
        if (move_idx == 2'd3) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_DONE;
      ST_LOOKUP: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------- fsm outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = s2_addr;
    mem_wdata = new_count;
    mem_raddr = step_addr;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (req == REQ_READ) mem_raddr = {cell_y, cell_x};
        else mem_raddr = {bishop_y, bishop_x};
      end
      ST_WALK:  mem_we = s2_valid;
      ST_DRAIN: mem_we = s2_valid;
      default: ;
    endcase
  end

  // ---------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      move_idx   <= '0;
      s2_valid   <= 1'b0;
      bishop_x   <= '0;
      bishop_y   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      s2_valid <= (state == ST_WALK);
      // result register fills when done, empties on a transfer
      out_valid <= (state == ST_DONE) || (out_valid && out_stall);
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_last && clr_report) begin
            bishop_x <= X_BITS'(start_coord(start_x, w_eff));
            bishop_y <= Y_BITS'(start_coord(start_y, h_eff));
          end
        end
        ST_IDLE: begin
          move_idx <= '0;
          if (in_xfer && req == REQ_START) begin
            clr_addr   <= '0;
            clr_report <= 1'b1;
          end
        end
        ST_WALK: begin
          move_idx <= move_idx + 2'd1;
          bishop_x <= step_x;
          bishop_y <= step_y;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    case (state)
      ST_CLEAR: res_count <= '0;
      ST_IDLE: begin
        walk_byte <= data_byte;
        in_grid   <= (req != REQ_READ) ||
                     ((CFG_BITS'(cell_x) < w_eff) && (CFG_BITS'(cell_y) < h_eff));
      end
      ST_WALK: begin
        walk_byte  <= high_first ? {walk_byte[5:0], 2'b00} : {2'b00, walk_byte[7:2]};
        s2_addr    <= step_addr;
        s2_fwd     <= s2_valid && (s2_addr == step_addr);
        s2_fwd_val <= new_count;
        if (s2_valid) res_count <= new_count;
      end
      ST_DRAIN:  res_count <= new_count;
      ST_LOOKUP: res_count <= in_grid ? mem_rdata : '0;
      default: ;
    endcase
    if (state == ST_DONE && out_free) begin
      visit_count  <= 8'(res_count);
      symbol_index <= 4'((res_count > SYM_LAST) ? SYM_LAST : res_count);
      pos_x        <= 5'(bishop_x);
      pos_y        <= 5'(bishop_y);
    end
  end

  dbr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ------------------------------------------------------------ assertions
  `include "drunken_bishop_randomart_unit_assert.svh"

  `DBR_ASSERT_NOW(a_fwd_follows_move, s2_fwd && s2_valid && state == ST_WALK, $past(s2_valid), "stray forward")
  `DBR_ASSERT_NOW(a_drain_has_move, state == ST_DRAIN, s2_valid, "drain without a write")
  `DBR_ASSERT_NOW(a_clear_no_rmw, state == ST_CLEAR, !s2_valid, "write during clear")
  `DBR_ASSERT_NEXT(a_walk_in_grid, state == ST_DRAIN, (6'(bishop_x) < w_eff) && (6'(bishop_y) < h_eff), "off grid")

endmodule
